/* hdl/plb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plb_pkg
// Shared types and constants for the positional list buffer.
// ----------------------------------------------------------------------------
package plb_pkg;

  // Positions are 5 bits wide, so the list stays well inside that range.
  localparam int LIST_DEPTH = 16;
  localparam int IDX_W      = $clog2(LIST_DEPTH);
  localparam int POS_W      = 5;
  localparam int CNT_W      = 5;
  localparam int DATA_W     = 32;

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(LIST_DEPTH);

  localparam logic [1:0] OP_READ   = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_RANGE = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]               opcode;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [DATA_W-1:0] read_value;
    logic [CNT_W-1:0]         list_length;
  } out_word_t;

  typedef struct packed {
    logic load_in;
    logic commit;
  } plb_cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } ctl_state_t;

endpackage

/* hdl/positional_list_buffer_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_buffer_unit
// Ordered list of 32-bit words with read, insert and delete by position.
// ----------------------------------------------------------------------------
//  channel | ports                        | word
//  input   | in_valid, in_stall, in_data  | opcode, position, value
//  output  | out_valid, out_stall, out_data | status, read_value, list_length
//
//  Each word is first captured, then the datapath shifts the element
//  registers and loads the result register.
//  A new word is taken while the previous result still waits in out_data.
//  A stalled result holds the sequencer in its execute step.
//  Reset (rst_n low, synchronous) empties the list.
// ----------------------------------------------------------------------------
module positional_list_buffer_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  plb_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output plb_pkg::out_word_t out_data
);

  plb_pkg::plb_cmd_t cmd;

  plb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  plb_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .out_data (out_data)
  );

`ifndef ASSERT_OFF
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.list_length <= plb_pkg::DEPTH_CNT)
    else $error("list length exceeds capacity");

  a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == plb_pkg::STAT_FULL |->
    out_data.list_length == plb_pkg::DEPTH_CNT)
    else $error("full status with list not full");

  a_rd_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != plb_pkg::STAT_OK |-> out_data.read_value == '0)
    else $error("nonzero read value on failed operation");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second word taken while one is in flight");
`endif

endmodule

/* hdl/plb_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plb_ctrl
// Sequencer: takes a word, runs it through the datapath, hands off the result.
// ----------------------------------------------------------------------------
module plb_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output plb_pkg::plb_cmd_t cmd
);

  plb_pkg::ctl_state_t state_r, state_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      plb_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = plb_pkg::ST_EXEC;
      end
      plb_pkg::ST_EXEC: begin
        if (out_free) state_nxt = plb_pkg::ST_IDLE;
      end
      default: state_nxt = plb_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      plb_pkg::ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.load_in = in_valid;
      end
      plb_pkg::ST_EXEC: begin
        cmd.commit = out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= plb_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* hdl/plb_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plb_datapath
// Element register array with whole-list shift, length counter, result word.
// ----------------------------------------------------------------------------
module plb_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  plb_pkg::plb_cmd_t  cmd,
  input  plb_pkg::in_word_t  in_data,
  output plb_pkg::out_word_t out_data
);

  plb_pkg::in_word_t                 op_r;
  plb_pkg::out_word_t                res_r, res_nxt;
  logic signed [plb_pkg::DATA_W-1:0] store_r   [plb_pkg::LIST_DEPTH];
  logic signed [plb_pkg::DATA_W-1:0] store_nxt [plb_pkg::LIST_DEPTH];
  logic [plb_pkg::CNT_W-1:0]         count_r, count_nxt;

  logic [plb_pkg::POS_W-1:0] pos_m1;
  logic [plb_pkg::CNT_W:0]   pos_x, cnt_x;
  logic                      pos_nz, in_list, ins_ok, del_ok, full;

  assign pos_x   = {1'b0, op_r.position};
  assign cnt_x   = {1'b0, count_r};
  assign pos_m1  = op_r.position - 1'b1;
  assign pos_nz  = (op_r.position != '0);
  assign in_list = pos_nz && (pos_x <= cnt_x);
  assign full    = (count_r == plb_pkg::DEPTH_CNT);
  assign ins_ok  = (op_r.opcode == plb_pkg::OP_INSERT) && !full && pos_nz &&
                   (pos_x <= cnt_x + 1'b1);
  assign del_ok  = (op_r.opcode == plb_pkg::OP_DELETE) && in_list;

  // Each slot picks its neighbor, the new value, or holds.
  for (genvar i = 0; i < plb_pkg::LIST_DEPTH; i++) begin : g_slot
    localparam logic [plb_pkg::CNT_W:0] IX = (plb_pkg::CNT_W+1)'(i);
    always_comb begin
      store_nxt[i] = store_r[i];
      if (ins_ok) begin
        if (IX + 1'b1 == pos_x) begin
          store_nxt[i] = op_r.value;
        end else if (IX + 1'b1 > pos_x && IX <= cnt_x && i > 0) begin
          store_nxt[i] = store_r[(i > 0) ? i - 1 : 0];
        end
      end else if (del_ok) begin
        if (IX + 1'b1 >= pos_x && IX + 1'b1 < cnt_x && i < plb_pkg::LIST_DEPTH - 1) begin
          store_nxt[i] = store_r[(i < plb_pkg::LIST_DEPTH - 1) ? i + 1 : i];
        end
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (ins_ok) count_nxt = count_r + 1'b1;
    else if (del_ok) count_nxt = count_r - 1'b1;

    res_nxt             = '0;
    res_nxt.status      = plb_pkg::STAT_OK;
    res_nxt.list_length = count_nxt;
    unique case (op_r.opcode)
      plb_pkg::OP_READ: begin
        if (in_list) res_nxt.read_value = store_r[pos_m1[plb_pkg::IDX_W-1:0]];
        else res_nxt.status = plb_pkg::STAT_RANGE;
      end
      plb_pkg::OP_INSERT: begin
        if (full) res_nxt.status = plb_pkg::STAT_FULL;
        else if (!ins_ok) res_nxt.status = plb_pkg::STAT_RANGE;
      end
      plb_pkg::OP_DELETE: begin
        if (!del_ok) res_nxt.status = plb_pkg::STAT_RANGE;
      end
      default: res_nxt.status = plb_pkg::STAT_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.commit) begin
      count_r <= count_nxt;
    end
  end

  // Payload registers: slots past the length are never read, so no reset.
  always_ff @(posedge clk) begin
    if (cmd.load_in) op_r <= in_data;
    if (cmd.commit) begin
      res_r   <= res_nxt;
      store_r <= store_nxt;
    end
  end

  assign out_data = res_r;

endmodule
